// ===== src/rgb_hsl_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
package rgb_hsl_pkg;

   localparam int CHAN_W      = 8;
   localparam int HUE_W       = 15;
   localparam int HUE_ACC_W   = 24;
   localparam int SAT_ACC_W   = 17;
   localparam int DEN_W       = 9;
   localparam int SECT_W      = 11;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_STEPS   = 4;
   localparam int HUE_Q_W     = 15;
   localparam int SAT_Q_W     = 8;

   localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_hsl_req_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] lightness;
   } rgb_hsl_rsp_type;

   // Divider operands; accumulators hold {remainder, dividend bits / quotient bits}.
   typedef struct packed {
      logic [HUE_ACC_W-1:0] hue_acc;
      logic [DEN_W-1:0]     hue_den;
      logic [SAT_ACC_W-1:0] sat_acc;
      logic [DEN_W-1:0]     sat_den;
      logic [CHAN_W-1:0]    lightness;
      logic                 grey;
   } rgb_hsl_opnd_type;

endpackage

// ===== src/rgb_hsl_prep.sv =====
// Input register, channel extremes and divider operand generation (three stages).
module rgb_hsl_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  rgb_hsl_pkg::rgb_hsl_req_type  in_pixel,
   output logic                          out_valid,
   output rgb_hsl_pkg::rgb_hsl_opnd_type out_opnd
);
   import rgb_hsl_pkg::*;

   logic            a_valid_ff;
   rgb_hsl_req_type a_pix_ff;

   logic              b_valid_ff;
   logic [SECT_W-1:0] b_t_ff, b_t_in;
   logic [CHAN_W-1:0] b_d_ff, b_d_in;
   logic [8:0]        b_sum_ff, b_sum_in;

   logic              c_valid_ff;
   rgb_hsl_opnd_type  c_opnd_ff, c_opnd_in;

   logic [CHAN_W-1:0] mx, mn;
   logic [SECT_W-1:0] dx;

   // stage B: extremes, sector numerator over 3840
   always_comb begin
      mx = a_pix_ff.red;
      mn = a_pix_ff.red;
      if (a_pix_ff.green > mx) mx = a_pix_ff.green;
      if (a_pix_ff.blue  > mx) mx = a_pix_ff.blue;
      if (a_pix_ff.green < mn) mn = a_pix_ff.green;
      if (a_pix_ff.blue  < mn) mn = a_pix_ff.blue;
      b_sum_in = {1'b0, mx} + {1'b0, mn};
      b_d_in   = mx - mn;
      dx       = {3'b000, b_d_in};
      if (mx == a_pix_ff.red) begin
         if (a_pix_ff.green >= a_pix_ff.blue) begin
            b_t_in = {3'b000, 8'(a_pix_ff.green - a_pix_ff.blue)};
         end else begin
            b_t_in = (dx << 2) + (dx << 1) - {3'b000, 8'(a_pix_ff.blue - a_pix_ff.green)};
         end
      end else if (mx == a_pix_ff.green) begin
         if (a_pix_ff.blue >= a_pix_ff.red) begin
            b_t_in = (dx << 1) + {3'b000, 8'(a_pix_ff.blue - a_pix_ff.red)};
         end else begin
            b_t_in = (dx << 1) - {3'b000, 8'(a_pix_ff.red - a_pix_ff.blue)};
         end
      end else begin
         if (a_pix_ff.red >= a_pix_ff.green) begin
            b_t_in = (dx << 2) + {3'b000, 8'(a_pix_ff.red - a_pix_ff.green)};
         end else begin
            b_t_in = (dx << 2) - {3'b000, 8'(a_pix_ff.green - a_pix_ff.red)};
         end
      end
   end

   logic [HUE_ACC_W-1:0] tx;
   logic [SAT_ACC_W-1:0] dx17;
   logic [8:0]           den_w;
   logic [8:0]           sum_p1;

   // stage C: scaled dividends and divisors
   always_comb begin
      tx     = {13'd0, b_t_ff};
      dx17   = {9'd0, b_d_ff};
      den_w  = b_sum_ff[8] ? (9'd510 - b_sum_ff) : b_sum_ff;
      sum_p1 = b_sum_ff + 9'd1;
      c_opnd_in.hue_acc   = (tx << 13) - (tx << 9) + {16'd0, b_d_ff};
      c_opnd_in.hue_den   = {b_d_ff, 1'b0};
      c_opnd_in.sat_acc   = (dx17 << 9) - (dx17 << 1) + {9'd0, den_w[7:0]};
      c_opnd_in.sat_den   = {den_w[7:0], 1'b0};
      c_opnd_in.lightness = sum_p1[8:1];
      c_opnd_in.grey      = (b_d_ff == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_pix_ff  <= in_pixel;
      b_t_ff    <= b_t_in;
      b_d_ff    <= b_d_in;
      b_sum_ff  <= b_sum_in;
      c_opnd_ff <= c_opnd_in;
   end

   assign out_valid = c_valid_ff;
   assign out_opnd  = c_opnd_ff;

endmodule

// ===== src/rgb_hsl_divider.sv =====
// Pipelined restoring divider for hue and saturation, four quotient bits per stage.
module rgb_hsl_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  rgb_hsl_pkg::rgb_hsl_opnd_type in_opnd,
   output logic                          out_valid,
   output rgb_hsl_pkg::rgb_hsl_opnd_type out_opnd
);
   import rgb_hsl_pkg::*;

   function automatic logic [HUE_ACC_W-1:0] hue_step(input logic [HUE_ACC_W-1:0] acc,
                                                     input logic [DEN_W-1:0] den);
      logic [DEN_W:0]   top;
      logic [DEN_W-1:0] rem;
      logic             q;
      top = acc[HUE_ACC_W-1:HUE_Q_W-1];
      if (top >= {1'b0, den}) begin
         rem = DEN_W'(top - {1'b0, den});
         q   = 1'b1;
      end else begin
         rem = top[DEN_W-1:0];
         q   = 1'b0;
      end
      return {rem, acc[HUE_Q_W-2:0], q};
   endfunction

   function automatic logic [SAT_ACC_W-1:0] sat_step(input logic [SAT_ACC_W-1:0] acc,
                                                     input logic [DEN_W-1:0] den);
      logic [DEN_W:0]   top;
      logic [DEN_W-1:0] rem;
      logic             q;
      top = acc[SAT_ACC_W-1:SAT_Q_W-1];
      if (top >= {1'b0, den}) begin
         rem = DEN_W'(top - {1'b0, den});
         q   = 1'b1;
      end else begin
         rem = top[DEN_W-1:0];
         q   = 1'b0;
      end
      return {rem, acc[SAT_Q_W-2:0], q};
   endfunction

   logic [DIV_STAGES-1:0] valid_ff;
   rgb_hsl_opnd_type      opnd_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      rgb_hsl_opnd_type opnd_src;
      rgb_hsl_opnd_type opnd_in;
      logic             valid_src;

      if (s == 0) begin : g_first
         assign opnd_src  = in_opnd;
         assign valid_src = in_valid;
      end else begin : g_next
         assign opnd_src  = opnd_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      always_comb begin
         opnd_in = opnd_src;
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (s * DIV_STEPS + j < HUE_Q_W) begin
               opnd_in.hue_acc = hue_step(opnd_in.hue_acc, opnd_in.hue_den);
            end
            if (s * DIV_STEPS + j < SAT_Q_W) begin
               opnd_in.sat_acc = sat_step(opnd_in.sat_acc, opnd_in.sat_den);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         opnd_ff[s] <= opnd_in;
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_opnd  = opnd_ff[DIV_STAGES-1];

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_opnd.grey |-> out_opnd.hue_acc[HUE_Q_W-1:0] <= HUE_FULL)
      else $error("hue quotient beyond full turn");

   a_hue_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_opnd.grey |-> out_opnd.hue_acc[HUE_ACC_W-1:HUE_Q_W] < out_opnd.hue_den)
      else $error("hue remainder not below divisor");

   a_sat_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_opnd.grey |-> out_opnd.sat_acc[SAT_ACC_W-1:SAT_Q_W] < out_opnd.sat_den)
      else $error("saturation remainder not below divisor");

endmodule

// ===== src/rgb_hsl_to_hsl_converter_placeholder.sv =====
// Output stage: hue wrap, grey override and result register.
module rgb_hsl_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  rgb_hsl_pkg::rgb_hsl_opnd_type in_opnd,
   output logic                          out_valid,
   output rgb_hsl_pkg::rgb_hsl_rsp_type  out_pixel
);
   import rgb_hsl_pkg::*;

   logic            valid_ff;
   rgb_hsl_rsp_type rsp_ff, rsp_in;
   logic [HUE_W-1:0] hue_q;

   always_comb begin
      hue_q = in_opnd.hue_acc[HUE_Q_W-1:0];
      if (hue_q >= HUE_FULL) begin
         hue_q = hue_q - HUE_FULL;
      end
      rsp_in.lightness = in_opnd.lightness;
      if (in_opnd.grey) begin
         rsp_in.hue        = '0;
         rsp_in.saturation = '0;
      end else begin
         rsp_in.hue        = hue_q;
         rsp_in.saturation = in_opnd.sat_acc[SAT_Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_pixel = rsp_ff;

endmodule

// ===== src/rgb_to_hsl_converter.sv =====
// Top level of the RGB to HSL converter.
//
// Usage:
//   A request is one pixel on req_rgb (red, green, blue, 8 bits each). It is
//   taken at a rising edge with start high and busy low. busy is low at all
//   times outside reset, so a pixel may be given in every cycle.
//   The result (hue in 1/64 degree, saturation and lightness 0..255) appears
//   on rsp_hsl with rsp_valid high for exactly one cycle, in request order.
//   Throughput is one pixel per cycle: three stages of operand preparation,
//   four stages of a restoring divider at four quotient bits per stage that
//   works hue and saturation side by side, and one output register.
//   The receiver cannot stall; results are never held back.
//   Reset is synchronous: it empties the pipeline, no result follows a request
//   still in flight, and busy is high while reset is asserted.
module rgb_to_hsl_converter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  rgb_hsl_pkg::rgb_hsl_req_type req_rgb,
   output logic                         rsp_valid,
   output rgb_hsl_pkg::rgb_hsl_rsp_type rsp_hsl
);
   import rgb_hsl_pkg::*;

   logic             accept;
   logic             prep_valid, div_valid;
   rgb_hsl_opnd_type prep_opnd, div_opnd;

   assign busy   = reset;
   assign accept = start && !busy;

   rgb_hsl_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pixel  (req_rgb),
      .out_valid (prep_valid),
      .out_opnd  (prep_opnd)
   );

   rgb_hsl_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_opnd   (prep_opnd),
      .out_valid (div_valid),
      .out_opnd  (div_opnd)
   );

   rgb_hsl_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_opnd   (div_opnd),
      .out_valid (rsp_valid),
      .out_pixel (rsp_hsl)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 8))
      else $error("result without matching request");

   a_hue_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hsl.hue < HUE_FULL)
      else $error("hue not wrapped");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hsl.saturation == '0 |-> rsp_hsl.hue == '0)
      else $error("zero saturation with non-zero hue");

endmodule
